// ===== sv/rmi_pkg.sv =====
// Package for the fully connected ReLU network inference block.
// Holds item structs, request codes, sizes and fixed-point constants; no dependencies.
package rmi_pkg;

  localparam int MAX_LAYERS = 4;
  localparam int MAX_WIDTH  = 16;
  localparam int DATA_BITS  = 16;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_BIAS    = 2'd1,
    REQ_FEATURE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_IN_FEATURES = 3'd1,
    REG_WIDTH0      = 3'd2,
    REG_WIDTH1      = 3'd3,
    REG_WIDTH2      = 3'd4,
    REG_WIDTH3      = 3'd5
  } reg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         layer_sel;
    logic [3:0]         row_sel;
    logic [3:0]         col_sel;
    logic signed [15:0] data_value;
    logic               last_feature;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [3:0]         out_index;
    logic               status;
    logic               last_out;
  } out_item_t;

endpackage

// ===== sv/rmi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/rmi_mac.sv =====
// Shared multiply-accumulate unit with rounding, saturation and ReLU.
// Depends on rmi_pkg for FRAC_BITS.
module rmi_mac #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        clear,
  input  logic signed [DATA_BITS-1:0] bias,
  input  logic                        mul_en,
  input  logic signed [DATA_BITS-1:0] a,
  input  logic signed [DATA_BITS-1:0] b,
  input  logic                        acc_en,
  input  logic                        relu,
  output logic signed [DATA_BITS-1:0] result
);
  localparam int PW = 2 * DATA_BITS;
  localparam int AW = PW + 6;

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] shr;
  logic signed [AW-1:0] hi;
  logic signed [AW-1:0] lo;
  logic signed [DATA_BITS-1:0] sat;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= a * b;
    end
    if (clear) begin
      acc <= AW'(bias) <<< rmi_pkg::FRAC_BITS;
    end else if (acc_en) begin
      acc <= acc + AW'(prod);
    end
  end

  always_comb begin
    hi  = AW'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
    lo  = -(AW'(64'sd1 <<< (DATA_BITS - 1)));
    rnd = acc + AW'(1 <<< (rmi_pkg::FRAC_BITS - 1));
    shr = rnd >>> rmi_pkg::FRAC_BITS;
    if (shr > hi) begin
      sat = hi[DATA_BITS-1:0];
    end else if (shr < lo) begin
      sat = lo[DATA_BITS-1:0];
    end else begin
      sat = shr[DATA_BITS-1:0];
    end
    result = (relu && sat[DATA_BITS-1]) ? '0 : sat;
  end
endmodule

// ===== sv/relu_mlp_inference.sv =====
// Top level of the fully connected ReLU network inference block.
// Depends on rmi_pkg, rmi_ram and rmi_mac.
//
//  channel   signals                       direction  accepted when
//  input     start, busy, in_item          in         start && !busy
//  result    out_valid, out_item           out        out_valid (no stall)
//  config    psel..pready, paddr, pwdata   in         psel&&penable&&pwrite
//
// Weight, bias and non-last feature items are taken without raising busy.
// A last feature runs the sample, or gives one error item if the feature count
// is wrong: each neuron passes through bias read, nin products on the single
// MAC, drain and store, layer after layer; then one output is shown per cycle.
// Neurons are worked one at a time on the MAC and its one weight-memory read port.
// Reset is synchronous; weight and bias memories are not cleared.
// Results cannot be stalled; busy stays high until the last one is shown.
module relu_mlp_inference (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rmi_pkg::in_item_t   in_item,
  output logic                out_valid,
  output rmi_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int MAX_LAYERS = rmi_pkg::MAX_LAYERS;
  localparam int MAX_WIDTH  = rmi_pkg::MAX_WIDTH;
  localparam int DATA_BITS  = rmi_pkg::DATA_BITS;
  localparam int LB  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int WB  = $clog2(MAX_WIDTH);
  localparam int WD  = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int BD  = MAX_LAYERS * MAX_WIDTH;
  localparam int WAB = $clog2(WD);
  localparam int BAB = $clog2(BD);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BIAS  = 7'b0000010,
    S_MAC   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_STORE = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] layer_count;
  logic [4:0] in_features;
  logic [4:0] width_layer [4];

  logic [DATA_BITS-1:0] act [2][MAX_WIDTH];
  logic [4:0] feature_count;
  logic [LB:0] layer;
  logic [WB:0] row;
  logic [WB:0] col;
  logic [WB:0] nin;
  logic src;
  logic [1:0] pipe;

  logic [LB:0] nl;
  logic [WB:0] nout;
  logic [4:0] wsel;
  logic accept;
  logic cfg_we;
  logic w_we, b_we;
  logic [WAB-1:0] w_waddr, w_raddr;
  logic [BAB-1:0] b_waddr, b_raddr;
  logic [DATA_BITS-1:0] w_rdata, b_rdata;
  logic [DATA_BITS-1:0] mac_result;
  logic last_layer;
  logic mac_clear;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    unique case (paddr[4:2])
      rmi_pkg::REG_LAYER_COUNT: prdata = {29'd0, layer_count};
      rmi_pkg::REG_IN_FEATURES: prdata = {27'd0, in_features};
      rmi_pkg::REG_WIDTH0:      prdata = {27'd0, width_layer[0]};
      rmi_pkg::REG_WIDTH1:      prdata = {27'd0, width_layer[1]};
      rmi_pkg::REG_WIDTH2:      prdata = {27'd0, width_layer[2]};
      rmi_pkg::REG_WIDTH3:      prdata = {27'd0, width_layer[3]};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (layer_count == 3'd0) begin
      nl = (LB+1)'(1);
    end else if (32'(layer_count) > MAX_LAYERS) begin
      nl = (LB+1)'(MAX_LAYERS);
    end else begin
      nl = (LB+1)'(layer_count);
    end
    wsel = (layer < (LB+1)'(4)) ? width_layer[layer[1:0]] : 5'd1;
    if (wsel == 5'd0) begin
      nout = (WB+1)'(1);
    end else if (32'(wsel) > MAX_WIDTH) begin
      nout = (WB+1)'(MAX_WIDTH);
    end else begin
      nout = (WB+1)'(wsel);
    end
    last_layer = (layer + (LB+1)'(1) == nl);
  end

  assign w_we    = accept && in_item.req_type == rmi_pkg::REQ_WEIGHT
                   && 32'(in_item.layer_sel) < MAX_LAYERS
                   && 32'(in_item.row_sel) < MAX_WIDTH
                   && 32'(in_item.col_sel) < MAX_WIDTH;
  assign b_we    = accept && in_item.req_type == rmi_pkg::REQ_BIAS
                   && 32'(in_item.layer_sel) < MAX_LAYERS
                   && 32'(in_item.row_sel) < MAX_WIDTH;
  assign w_waddr = WAB'((32'(in_item.layer_sel) * MAX_WIDTH + 32'(in_item.row_sel))
                   * MAX_WIDTH + 32'(in_item.col_sel));
  assign b_waddr = BAB'(32'(in_item.layer_sel) * MAX_WIDTH + 32'(in_item.row_sel));
  assign w_raddr = WAB'((32'(layer) * MAX_WIDTH + 32'(row)) * MAX_WIDTH + 32'(col));
  assign b_raddr = BAB'(32'(layer) * MAX_WIDTH + 32'(row));

  rmi_ram #(.WIDTH(DATA_BITS), .DEPTH(WD)) u_wram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_item.data_value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  rmi_ram #(.WIDTH(DATA_BITS), .DEPTH(BD)) u_bram (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(in_item.data_value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  logic [DATA_BITS-1:0] act_rd;

  always_ff @(posedge clk) begin
    act_rd <= act[src][col[WB-1:0]];
  end

  // load the bias once its registered read is valid
  assign mac_clear = (state == S_MAC) && (col == '0);

  rmi_mac #(.DATA_BITS(DATA_BITS)) u_mac (
    .clk, .clear(mac_clear), .bias(DATA_BITS'(signed'(b_rdata))),
    .mul_en(pipe[0]), .a(DATA_BITS'(signed'(w_rdata))), .b(act_rd),
    .acc_en(pipe[1]), .relu(!last_layer), .result(mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      layer_count <= 3'd1;
      in_features <= 5'd1;
      for (int i = 0; i < 4; i++) begin
        width_layer[i] <= 5'd1;
      end
      feature_count <= '0;
      out_valid <= 1'b0;
      pipe <= '0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[4:2])
          rmi_pkg::REG_LAYER_COUNT: layer_count <= pwdata[2:0];
          rmi_pkg::REG_IN_FEATURES: in_features <= pwdata[4:0];
          rmi_pkg::REG_WIDTH0:      width_layer[0] <= pwdata[4:0];
          rmi_pkg::REG_WIDTH1:      width_layer[1] <= pwdata[4:0];
          rmi_pkg::REG_WIDTH2:      width_layer[2] <= pwdata[4:0];
          rmi_pkg::REG_WIDTH3:      width_layer[3] <= pwdata[4:0];
          default: ;
        endcase
      end
      if (accept && in_item.req_type == rmi_pkg::REQ_FEATURE
          && 32'(feature_count) < MAX_WIDTH) begin
        act[0][feature_count[WB-1:0]] <= DATA_BITS'(in_item.data_value);
      end
      if (state == S_STORE) begin
        act[~src][row[WB-1:0]] <= mac_result;
      end
      out_valid <= (state == S_OUT) || (state == S_ERR);
      pipe <= {pipe[0], state == S_MAC};
      unique case (state)
        S_IDLE: begin
          if (accept && in_item.req_type == rmi_pkg::REQ_FEATURE) begin
            if (in_item.last_feature) begin
              feature_count <= '0;
            end else if (feature_count != 5'd31) begin
              feature_count <= feature_count + 5'd1;
            end
            if (in_item.last_feature) begin
              layer <= '0;
              row   <= '0;
              col   <= '0;
              src   <= 1'b0;
              if (in_features == 5'd0 || 32'(in_features) > MAX_WIDTH
                  || ((feature_count == 5'd31) ? 5'd31 : feature_count + 5'd1)
                     != in_features) begin
                state <= S_ERR;
              end else begin
                nin   <= (WB+1)'(in_features);
                state <= S_BIAS;
              end
            end
          end
        end
        S_BIAS: begin
          state <= S_MAC;
        end
        S_MAC: begin
          col <= col + (WB+1)'(1);
          if (col + (WB+1)'(1) == nin) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe[0] && !pipe[1]) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          col <= '0;
          if (row + (WB+1)'(1) == nout) begin
            row <= '0;
            src <= ~src;
            nin <= nout;
            if (last_layer) begin
              state <= S_OUT;
            end else begin
              layer <= layer + (LB+1)'(1);
              state <= S_BIAS;
            end
          end else begin
            row   <= row + (WB+1)'(1);
            state <= S_BIAS;
          end
        end
        S_OUT: begin
          out_item.out_value <= act[src][row[WB-1:0]];
          out_item.out_index <= 4'(row);
          out_item.status <= 1'b0;
          out_item.last_out <= (row + (WB+1)'(1) == nin);
          row <= row + (WB+1)'(1);
          if (row + (WB+1)'(1) == nin) begin
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          out_item <= '{out_value: '0, out_index: '0, status: 1'b1, last_out: 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/rmi_checker.sv =====
// Port-level checker for relu_mlp_inference, bound to the top level.
// Depends on rmi_pkg for the item structs.
module rmi_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               out_valid,
  input rmi_pkg::out_item_t out_item,
  input logic               pready
);
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy))
    else $error("result without busy");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.last_out && out_item.out_index == 4'd0)
    else $error("bad error item");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_out |-> !busy)
    else $error("busy after last");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !busy && !out_valid)
    else $error("not idle after reset");
endmodule

bind relu_mlp_inference rmi_checker u_rmi_checker (
  .clk, .rst, .busy, .out_valid, .out_item, .pready
);

// ===== verif/tb_relu_mlp_inference.sv =====
// Testbench for relu_mlp_inference: directed table then random network loads and samples.
// Predicts results from its own fixed-point network model; depends on rmi_pkg and the RTL.
module tb_relu_mlp_inference;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  rmi_pkg::in_item_t in_item;
  logic out_valid;
  rmi_pkg::out_item_t out_item;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  relu_mlp_inference i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int LIMIT = 3000000;

  // network state mirror
  logic [2:0] n_layers;
  logic [4:0] n_in;
  logic [4:0] widths [4];
  logic signed [15:0] weights [4][16][16];
  logic signed [15:0] biases [4][16];
  logic signed [15:0] acts [2][16];
  logic [4:0] feat_cnt;

  rmi_pkg::out_item_t pending_outputs [$];
  int mismatches;
  int accepted;
  int outputs_seen;
  int samples_run;
  int errors_seen;
  int cycle_cnt;
  logic sender_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [15:0] requant(longint acc);
    longint v;
    v = acc + 128;
    if (v >= 64'sd32768 * 256) return 16'sh7fff;
    if (v < -64'sd32768 * 256) return 16'sh8000;
    return 16'(v >>> 8);
  endfunction

  function automatic int used_layers();
    return n_layers == 0 ? 1 : (n_layers > 4 ? 4 : int'(n_layers));
  endfunction

  function automatic int used_width(int l);
    return widths[l] == 0 ? 1 : (widths[l] > 16 ? 16 : int'(widths[l]));
  endfunction

  task automatic predict_network(rmi_pkg::in_item_t it);
    int nl, nin, nout, src, dst;
    longint acc;
    logic signed [15:0] y;
    rmi_pkg::out_item_t o;
    if (it.req_type == rmi_pkg::REQ_WEIGHT) begin
      weights[it.layer_sel][it.row_sel][it.col_sel] = it.data_value;
      return;
    end
    if (it.req_type == rmi_pkg::REQ_BIAS) begin
      biases[it.layer_sel][it.row_sel] = it.data_value;
      return;
    end
    if (it.req_type != rmi_pkg::REQ_FEATURE) return;
    if (feat_cnt < 16) acts[0][feat_cnt[3:0]] = it.data_value;
    if (feat_cnt < 31) feat_cnt++;
    if (!it.last_feature) return;
    if (n_in == 0 || n_in > 16 || feat_cnt != n_in) begin
      feat_cnt = 0;
      o = '{out_value: 16'sd0, out_index: 4'd0, status: 1'b1, last_out: 1'b1};
      pending_outputs = {pending_outputs, o};
      return;
    end
    feat_cnt = 0;
    nl = used_layers();
    nin = n_in;
    src = 0;
    nout = 1;
    for (int l = 0; l < nl; l++) begin
      dst = src ^ 1;
      nout = used_width(l);
      for (int r = 0; r < nout; r++) begin
        acc = longint'(biases[l][r]) * 256;
        for (int c = 0; c < nin; c++) acc += longint'(weights[l][r][c]) * longint'(acts[src][c]);
        y = requant(acc);
        if (l + 1 < nl && y < 0) y = 0;
        acts[dst][r] = y;
      end
      nin = nout;
      src = dst;
    end
    for (int r = 0; r < nout; r++) begin
      o = '{out_value: acts[src][r], out_index: 4'(r), status: 1'b0,
            last_out: (r + 1 == nout)};
      pending_outputs = {pending_outputs, o};
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && out_valid) begin
      outputs_seen++;
      if (out_item.status) errors_seen++;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %p", out_item);
      end else begin
        rmi_pkg::out_item_t e;
        e = pending_outputs.pop_front();
        if (out_item !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(rmi_pkg::reg_t r, logic [4:0] val);
    start <= 0;
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {r, 2'b00}; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (r)
      rmi_pkg::REG_LAYER_COUNT: n_layers = val[2:0];
      rmi_pkg::REG_IN_FEATURES: n_in = val;
      rmi_pkg::REG_WIDTH0: widths[0] = val;
      rmi_pkg::REG_WIDTH1: widths[1] = val;
      rmi_pkg::REG_WIDTH2: widths[2] = val;
      default: widths[3] = val;
    endcase
  endtask

  // hold start across back-to-back items; drop it only before a gap
  task automatic send_item(rmi_pkg::in_item_t it);
    int gap;
    if (!sender_on) begin
      start <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      sender_on = 1;
    end else if ($urandom_range(0, 7) == 0) begin
      sender_on = 0;
    end
    start <= 1;
    in_item <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    accepted++;
    predict_network(it);
  endtask

  task automatic drain_outputs;
    start <= 0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic rmi_pkg::in_item_t mk(rmi_pkg::req_t t, int l, int r, int c, int v,
                                           bit last);
    rmi_pkg::in_item_t it;
    it.req_type = t;
    it.layer_sel = 2'(l);
    it.row_sel = 4'(r);
    it.col_sel = 4'(c);
    it.data_value = 16'(v);
    it.last_feature = last;
    return it;
  endfunction

  // load every weight and bias the current shape reads
  task automatic load_net;
    int nl, nin, nout;
    nl = used_layers();
    nin = n_in;
    for (int l = 0; l < nl; l++) begin
      nout = used_width(l);
      for (int r = 0; r < nout; r++) begin
        for (int c = 0; c < nin; c++)
          send_item(mk(rmi_pkg::REQ_WEIGHT, l, r, c, $urandom_range(0, 1023) - 512,
                       $urandom_range(0, 1)));
        send_item(mk(rmi_pkg::REQ_BIAS, l, r, $urandom_range(0, 15),
                     $urandom_range(0, 4095) - 2048, $urandom_range(0, 1)));
      end
      nin = nout;
    end
  endtask

  task automatic send_sample(int n, int wide);
    int v;
    for (int i = 0; i < n; i++) begin
      v = wide ? $urandom_range(0, 65535) : $urandom_range(0, 1023) - 512;
      send_item(mk(rmi_pkg::REQ_FEATURE, $urandom_range(0, 3), $urandom_range(0, 15),
                   $urandom_range(0, 15), v, i == n - 1));
    end
  endtask

  rmi_pkg::in_item_t dir_items [$];

  initial begin
    int n;
    rst = 1; start = 0; in_item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    mismatches = 0; accepted = 0; outputs_seen = 0; samples_run = 0; errors_seen = 0;
    cycle_cnt = 0; sender_on = 1;
    n_layers = 1; n_in = 1; feat_cnt = 0;
    foreach (widths[i]) widths[i] = 1;
    foreach (weights[a, b, c]) weights[a][b][c] = 0;
    foreach (biases[a, b]) biases[a][b] = 0;
    foreach (acts[a, b]) acts[a][b] = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: reset config, one-neuron net, extremes, saturation, error cases
    dir_items = {
      mk(rmi_pkg::REQ_NONE, 3, 15, 15, 16'h7fff, 1),
      mk(rmi_pkg::REQ_WEIGHT, 0, 0, 0, 16'h7fff, 1),
      mk(rmi_pkg::REQ_BIAS, 0, 0, 0, 16'h7fff, 1),
      mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, 16'h7fff, 1),
      mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, 16'h8000, 1),
      mk(rmi_pkg::REQ_WEIGHT, 0, 0, 0, 16'h0100, 0),
      mk(rmi_pkg::REQ_BIAS, 0, 0, 0, 16'h0000, 0),
      mk(rmi_pkg::REQ_FEATURE, 3, 15, 15, 16'h0180, 1),
      mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, 16'hff80, 1),
      mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, 16'h0001, 0),
      mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, 16'h0001, 1)
    };
    for (int i = 0; i < 17; i++)
      dir_items = {dir_items, mk(rmi_pkg::REQ_FEATURE, 0, 0, 0, i, i == 16)};
    foreach (dir_items[i]) send_item(dir_items[i]);
    drain_outputs();

    // extreme config: most layers, most features, widest output layer
    write_reg(rmi_pkg::REG_LAYER_COUNT, 4);
    write_reg(rmi_pkg::REG_IN_FEATURES, 16);
    write_reg(rmi_pkg::REG_WIDTH0, 2);
    write_reg(rmi_pkg::REG_WIDTH1, 1);
    write_reg(rmi_pkg::REG_WIDTH2, 1);
    write_reg(rmi_pkg::REG_WIDTH3, 16);
    load_net();
    for (int s = 0; s < 3; s++) send_sample(16, s == 0);
    send_sample(15, 0);
    drain_outputs();

    // out-of-range register values
    write_reg(rmi_pkg::REG_LAYER_COUNT, 0);
    write_reg(rmi_pkg::REG_IN_FEATURES, 0);
    write_reg(rmi_pkg::REG_WIDTH0, 0);
    send_sample(2, 1);
    write_reg(rmi_pkg::REG_IN_FEATURES, 20);
    write_reg(rmi_pkg::REG_WIDTH0, 31);
    send_sample(3, 1);
    drain_outputs();
    write_reg(rmi_pkg::REG_LAYER_COUNT, 7);
    write_reg(rmi_pkg::REG_IN_FEATURES, 2);
    write_reg(rmi_pkg::REG_WIDTH0, 0);
    write_reg(rmi_pkg::REG_WIDTH1, 17);
    write_reg(rmi_pkg::REG_WIDTH2, 0);
    write_reg(rmi_pkg::REG_WIDTH3, 3);
    load_net();
    send_sample(2, 0);
    drain_outputs();

    // random small shapes
    while (accepted < 380) begin
      write_reg(rmi_pkg::REG_LAYER_COUNT, $urandom_range(1, 4));
      write_reg(rmi_pkg::REG_IN_FEATURES, $urandom_range(1, 4));
      write_reg(rmi_pkg::REG_WIDTH0, $urandom_range(1, 4));
      write_reg(rmi_pkg::REG_WIDTH1, $urandom_range(1, 4));
      write_reg(rmi_pkg::REG_WIDTH2, $urandom_range(1, 4));
      write_reg(rmi_pkg::REG_WIDTH3, $urandom_range(1, 4));
      load_net();
      repeat (6) begin
        n = 0;
        case ($urandom_range(0, 9))
          0: n = n_in + 1;
          1: n = (n_in > 1) ? n_in - 1 : 2;
          2: send_item(mk(rmi_pkg::REQ_NONE, $urandom_range(0, 3), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 65535), 1));
          3: send_item(mk($urandom_range(0, 1) ? rmi_pkg::REQ_WEIGHT : rmi_pkg::REQ_BIAS,
                          $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 1023) - 512, $urandom_range(0, 1)));
          default: n = n_in;
        endcase
        if (n != 0) begin
          send_sample(n, $urandom_range(0, 3) == 0);
          samples_run++;
        end
      end
      drain_outputs();
    end

    drain_outputs();
    $display("Ran %0d items, %0d random samples over varied layer shapes; %0d results (%0d errors).",
             accepted, samples_run, outputs_seen, errors_seen);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_outputs.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rmi_pkg.sv
sv/rmi_ram.sv
sv/rmi_mac.sv
sv/relu_mlp_inference.sv
sv/rmi_checker.sv
verif/tb_relu_mlp_inference.sv
